// ----- src/jsu_pkg.sv -----
// shared types and constants for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int CAP_LIMIT_INT = (BUFFER_BYTES < 256) ? BUFFER_BYTES : 256;
    localparam logic [8:0] CAP_LIMIT = 9'(CAP_LIMIT_INT);

    localparam logic [1:0] REG_CAPACITY      = 2'd0;
    localparam logic [1:0] REG_CAPTURE_EN    = 2'd1;
    localparam logic [1:0] REG_REJECT_EMPTY  = 2'd2;

    localparam logic [8:0] CAPACITY_RESET = 9'd256;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_TEXT = 2'd1,
        PH_ESC  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOQUOTE = 3'd1,
        ST_CONTROL = 3'd2,
        ST_ESCAPE  = 3'd3,
        ST_UNTERM  = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef struct packed {
        logic [8:0] capacity;
        logic       capture_enable;
        logic       reject_empty;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] stored_count;
        logic       saw_char;
        logic       overflowed;
        logic       has_lead;
        logic [7:0] lead_position;
        logic [7:0] lead_value;
    } str_state_t;

    typedef struct packed {
        logic       valid;
        logic       is_done;
        logic [7:0] char_out;
        logic [7:0] char_index;
        logic [7:0] final_length;
        status_t    status;
        logic       truncated;
    } result_t;

    localparam str_state_t STATE_CLEAR = '{
        phase: PH_WAIT, stored_count: 8'd0, saw_char: 1'b0, overflowed: 1'b0,
        has_lead: 1'b0, lead_position: 8'd0, lead_value: 8'd0
    };

endpackage

// ----- src/jsu_cfg.sv -----
// configuration registers
`timescale 1ns / 1ps

module jsu_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [8:0]    cfg_wdata,
    output jsu_pkg::cfg_t cfg
);
    import jsu_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CAPACITY:     cfg_next.capacity = cfg_wdata;
                REG_CAPTURE_EN:   cfg_next.capture_enable = cfg_wdata[0];
                REG_REJECT_EMPTY: cfg_next.reject_empty = cfg_wdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.capacity       <= CAPACITY_RESET;
            cfg_reg.capture_enable <= 1'b1;
            cfg_reg.reject_empty   <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/jsu_step.sv -----
// per-byte decode: next string state and the result item, if any
`timescale 1ns / 1ps

module jsu_step (
    input  jsu_pkg::cfg_t       cfg,
    input  jsu_pkg::str_state_t cur,
    input  logic [7:0]          byte_in,
    output jsu_pkg::str_state_t nxt,
    output jsu_pkg::result_t    res
);
    import jsu_pkg::*;

    logic [8:0] eff_cap;
    logic [8:0] count_plus;
    logic [2:0] need;
    logic [8:0] tail_len;
    logic [7:0] trim_len;

    // effective capacity and trailing utf-8 trim, computed from current state
    always_comb begin
        eff_cap    = (cfg.capacity > CAP_LIMIT) ? CAP_LIMIT : cfg.capacity;
        count_plus = {1'b0, cur.stored_count} + 9'd1;
        if (cur.lead_value[7] == 1'b0)              need = 3'd1;
        else if (cur.lead_value[7:5] == 3'b110)     need = 3'd2;
        else if (cur.lead_value[7:4] == 4'b1110)    need = 3'd3;
        else if (cur.lead_value[7:3] == 5'b11110)   need = 3'd4;
        else                                        need = 3'd0;
        tail_len = {1'b0, cur.stored_count} - {1'b0, cur.lead_position};
        trim_len = cur.stored_count;
        if (cur.overflowed && (cur.stored_count != 8'd0) && cur.has_lead &&
            ((need == 3'd0) || (tail_len < {6'd0, need}))) begin
            trim_len = cur.lead_position;
        end
    end

    always_comb begin
        logic       do_store;
        logic [7:0] ch;
        nxt      = cur;
        res      = '0;
        do_store = 1'b0;
        ch       = byte_in;

        unique case (cur.phase)
            PH_TEXT: begin
                if (byte_in == CH_NUL) begin
                    nxt = STATE_CLEAR;
                    res.valid = 1'b1; res.is_done = 1'b1; res.status = ST_UNTERM;
                end else if (byte_in == CH_QUOTE) begin
                    nxt = STATE_CLEAR;
                    res.valid        = 1'b1;
                    res.is_done      = 1'b1;
                    res.final_length = trim_len;
                    res.truncated    = cur.overflowed;
                    res.status       = (cfg.reject_empty && !cur.saw_char) ?
                                       ST_EMPTY : ST_OK;
                end else if (byte_in < CH_SPACE) begin
                    nxt = STATE_CLEAR;
                    res.valid = 1'b1; res.is_done = 1'b1; res.status = ST_CONTROL;
                end else if (byte_in == CH_BSLASH) begin
                    nxt.saw_char = 1'b1;
                    nxt.phase    = PH_ESC;
                end else begin
                    do_store = 1'b1;
                end
            end
            PH_ESC: begin
                if (byte_in == CH_NUL) begin
                    nxt = STATE_CLEAR;
                    res.valid = 1'b1; res.is_done = 1'b1; res.status = ST_UNTERM;
                end else if (byte_in == CH_B || byte_in == CH_F || byte_in == CH_N ||
                             byte_in == CH_R || byte_in == CH_T) begin
                    ch        = CH_SPACE;
                    nxt.phase = PH_TEXT;
                    do_store  = 1'b1;
                end else if (byte_in == CH_QUOTE || byte_in == CH_BSLASH ||
                             byte_in == CH_SLASH) begin
                    nxt.phase = PH_TEXT;
                    do_store  = 1'b1;
                end else begin
                    nxt = STATE_CLEAR;
                    res.valid = 1'b1; res.is_done = 1'b1; res.status = ST_ESCAPE;
                end
            end
            default: begin
                // waiting for the opening quote, also the unused phase code
                nxt = STATE_CLEAR;
                if (byte_in != CH_QUOTE ||
                    (cfg.capture_enable && cfg.capacity == 9'd0)) begin
                    res.valid = 1'b1; res.is_done = 1'b1; res.status = ST_NOQUOTE;
                end else begin
                    nxt.phase = PH_TEXT;
                end
            end
        endcase

        if (do_store) begin
            nxt.saw_char = 1'b1;
            if (cfg.capture_enable) begin
                if (count_plus < eff_cap) begin
                    // continuation bytes do not move the lead marker
                    if (ch[7:6] != 2'b10) begin
                        nxt.has_lead      = 1'b1;
                        nxt.lead_position = cur.stored_count;
                        nxt.lead_value    = ch;
                    end
                    nxt.stored_count = count_plus[7:0];
                    res.valid      = 1'b1;
                    res.char_out   = ch;
                    res.char_index = cur.stored_count;
                end else begin
                    nxt.overflowed = 1'b1;
                end
            end
        end
    end

endmodule

// ----- src/json_string_unescape_truncate.sv -----
// top level: input register, decode step, result register
//
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_byte_in
// m_       out  m_valid/m_ready    m_is_done m_char_out m_char_index
//                                  m_final_length m_status m_truncated
// cfg_     in   cfg_wr_en          cfg_index cfg_wdata
//
// one byte per cycle unless m_ready low holds a result; a byte's result, if any,
// is loaded into the result register when the byte leaves the input register,
// and at most one result comes from each byte.
// string state advances when the byte leaves the input register, so a result
// held by m_ready low holds both stages and back-pressures s_ready.
// reset (aresetn low, synchronous) empties both stages, returns the string
// state to waiting for a quote and loads the register defaults.
`timescale 1ns / 1ps

module json_string_unescape_truncate (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [8:0]       cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_byte_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_is_done,
    output logic [7:0]       m_char_out,
    output logic [7:0]       m_char_index,
    output logic [7:0]       m_final_length,
    output logic [2:0]       m_status,
    output logic             m_truncated
);
    import jsu_pkg::*;

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    str_state_t state_reg;
    str_state_t state_next;
    result_t    step_res;
    result_t    out_reg;
    logic       advance;

    jsu_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    jsu_step u_step (
        .cfg     (cfg),
        .cur     (state_reg),
        .byte_in (in_byte_reg),
        .nxt     (state_next),
        .res     (step_res)
    );

    // the byte in the input register moves on once the result slot is free
    assign advance = in_valid_reg && (!out_reg.valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (advance) begin
            out_reg.valid <= step_res.valid;
        end else if (m_ready) begin
            out_reg.valid <= 1'b0;
        end
        if (advance && step_res.valid) begin
            out_reg.is_done      <= step_res.is_done;
            out_reg.char_out     <= step_res.char_out;
            out_reg.char_index   <= step_res.char_index;
            out_reg.final_length <= step_res.final_length;
            out_reg.status       <= step_res.status;
            out_reg.truncated    <= step_res.truncated;
        end
    end

    assign m_valid        = out_reg.valid;
    assign m_is_done      = out_reg.is_done;
    assign m_char_out     = out_reg.char_out;
    assign m_char_index   = out_reg.char_index;
    assign m_final_length = out_reg.final_length;
    assign m_status       = out_reg.status;
    assign m_truncated    = out_reg.truncated;

endmodule

// ----- tb/sv/json_string_unescape_truncate_test.sv -----
// testbench for the json string unescaper: directed and random streams against a predictor
`timescale 1ns / 1ps

module json_string_unescape_truncate_test;

    import jsu_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic       is_done;
        logic [7:0] char_out;
        logic [7:0] char_index;
        logic [7:0] final_length;
        status_t    status;
        logic       truncated;
    } unescape_result_t;

    localparam logic [7:0] ESC_LETTERS [8] = '{
        CH_B, CH_F, CH_N, CH_R, CH_T, CH_QUOTE, CH_BSLASH, CH_SLASH
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = REG_CAPACITY;
    logic [8:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_in = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_is_done;
    logic [7:0] m_char_out;
    logic [7:0] m_char_index;
    logic [7:0] m_final_length;
    logic [2:0] m_status;
    logic       m_truncated;

    // predictor copy of the registers and of the string state
    logic [8:0] cfg_capacity;
    logic       cfg_capture;
    logic       cfg_reject_empty;
    phase_t     str_phase;
    logic [7:0] stored_len;
    logic       got_char;
    logic       dropped;
    logic       lead_seen;
    logic [7:0] lead_pos;
    logic [7:0] lead_byte;

    unescape_result_t decoded_q [$];
    int mismatch_count = 0;
    int bytes_sent = 0;
    int idle_cycles = 0;
    int sink_hold = 0;
    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;

    json_string_unescape_truncate dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_in      (s_byte_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_is_done      (m_is_done),
        .m_char_out     (m_char_out),
        .m_char_index   (m_char_index),
        .m_final_length (m_final_length),
        .m_status       (m_status),
        .m_truncated    (m_truncated)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic void clear_string_state();
        str_phase  = PH_WAIT;
        stored_len = '0;
        got_char   = 1'b0;
        dropped    = 1'b0;
        lead_seen  = 1'b0;
        lead_pos   = '0;
        lead_byte  = '0;
    endfunction

    function automatic void report_error(input status_t st, output unescape_result_t r);
        clear_string_state();
        r = '0;
        r.is_done = 1'b1;
        r.status = st;
    endfunction

    function automatic bit store_char(input logic [7:0] ch, output unescape_result_t r);
        logic [8:0] limit;
        limit = (cfg_capacity > CAP_LIMIT) ? CAP_LIMIT : cfg_capacity;
        r = '0;
        got_char = 1'b1;
        if (!cfg_capture)
            return 1'b0;
        if ({1'b0, stored_len} + 9'd1 < limit) begin
            if (ch[7:6] != 2'b10) begin
                lead_seen = 1'b1;
                lead_pos  = stored_len;
                lead_byte = ch;
            end
            r.char_out = ch;
            r.char_index = stored_len;
            stored_len = stored_len + 8'd1;
            return 1'b1;
        end
        dropped = 1'b1;
        return 1'b0;
    endfunction

    // returns 1 when the byte produces a result
    function automatic bit decode_byte(input logic [7:0] b, output unescape_result_t r);
        logic [7:0] ch;
        logic [7:0] kept;
        logic [2:0] need;
        r = '0;
        case (str_phase)
            PH_TEXT: begin
                if (b == CH_NUL) begin
                    report_error(ST_UNTERM, r);
                    return 1'b1;
                end
                if (b == CH_QUOTE) begin
                    kept = stored_len;
                    // cut back a trailing utf-8 sequence broken by the capacity limit
                    if (dropped && kept != 8'd0 && lead_seen) begin
                        if (!lead_byte[7])
                            need = 3'd1;
                        else if (lead_byte[7:5] == 3'b110)
                            need = 3'd2;
                        else if (lead_byte[7:4] == 4'b1110)
                            need = 3'd3;
                        else if (lead_byte[7:3] == 5'b11110)
                            need = 3'd4;
                        else
                            need = 3'd0;
                        if (need == 3'd0 || (kept - lead_pos) < {5'd0, need})
                            kept = lead_pos;
                    end
                    r.is_done = 1'b1;
                    r.final_length = kept;
                    r.truncated = dropped;
                    r.status = (cfg_reject_empty && !got_char) ? ST_EMPTY : ST_OK;
                    clear_string_state();
                    return 1'b1;
                end
                if (b < CH_SPACE) begin
                    report_error(ST_CONTROL, r);
                    return 1'b1;
                end
                if (b == CH_BSLASH) begin
                    got_char = 1'b1;
                    str_phase = PH_ESC;
                    return 1'b0;
                end
                return store_char(b, r);
            end
            PH_ESC: begin
                if (b == CH_NUL) begin
                    report_error(ST_UNTERM, r);
                    return 1'b1;
                end
                if (b == CH_B || b == CH_F || b == CH_N || b == CH_R || b == CH_T)
                    ch = CH_SPACE;
                else if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH)
                    ch = b;
                else begin
                    report_error(ST_ESCAPE, r);
                    return 1'b1;
                end
                str_phase = PH_TEXT;
                return store_char(ch, r);
            end
            default: begin
                if (b != CH_QUOTE || (cfg_capture && cfg_capacity == 9'd0)) begin
                    report_error(ST_NOQUOTE, r);
                    return 1'b1;
                end
                clear_string_state();
                str_phase = PH_TEXT;
                return 1'b0;
            end
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        unescape_result_t r;
        int gap;
        s_valid <= 1'b1;
        s_byte_in <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (decode_byte(b, r))
            decoded_q.push_back(r);
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge aclk);
        // bytes with no result may still be in the pipeline
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_config(input logic [8:0] cap, input logic capture,
                              input logic reject_empty);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CAPACITY;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_capacity = cap;
        cfg_index <= REG_CAPTURE_EN;
        cfg_wdata <= {8'd0, capture};
        @(posedge aclk);
        cfg_capture = capture;
        cfg_index <= REG_REJECT_EMPTY;
        cfg_wdata <= {8'd0, reject_empty};
        @(posedge aclk);
        cfg_reject_empty = reject_empty;
        cfg_wr_en <= 1'b0;
    endtask

    // string content: plain text, escapes, utf-8 sequences (some cut short), stray high bytes
    task automatic send_body(input int units);
        int k;
        int n;
        int cut;
        logic [7:0] b;
        for (k = 0; k < units; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    b = 8'($urandom_range(8'h20, 8'h7E));
                    if (b == CH_QUOTE || b == CH_BSLASH)
                        b = 8'h41;
                    send_byte(b);
                end
                4, 5: begin
                    send_byte(CH_BSLASH);
                    send_byte(ESC_LETTERS[$urandom_range(0, 7)]);
                end
                6, 7, 8: begin
                    n = $urandom_range(2, 4);
                    if (n == 2)
                        b = 8'hC0 | 8'($urandom_range(0, 31));
                    else if (n == 3)
                        b = 8'hE0 | 8'($urandom_range(0, 15));
                    else
                        b = 8'hF0 | 8'($urandom_range(0, 7));
                    send_byte(b);
                    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 2) : n - 1;
                    repeat (cut) send_byte(8'h80 | 8'($urandom_range(0, 63)));
                end
                default: send_byte(8'($urandom_range(8'h80, 8'hFF)));
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input unescape_result_t got,
                                   input unescape_result_t want);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s at %0t: expected done=%0d char=%02h idx=%0d len=%0d st=%0d trunc=%0d",
                     what, $realtime,
                     want.is_done, want.char_out, want.char_index, want.final_length,
                     want.status, want.truncated);
            $display("    got done=%0d char=%02h idx=%0d len=%0d st=%0d trunc=%0d",
                     got.is_done, got.char_out, got.char_index, got.final_length,
                     got.status, got.truncated);
        end
    endtask

    always @(posedge aclk) begin : result_check
        unescape_result_t got;
        unescape_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.is_done = m_is_done;
            got.char_out = m_char_out;
            got.char_index = m_char_index;
            got.final_length = m_final_length;
            got.status = status_t'(m_status);
            got.truncated = m_truncated;
            if (decoded_q.size() == 0) begin
                want = '0;
                report_mismatch("unexpected result", got, want);
            end else begin
                want = decoded_q.pop_front();
                if (got !== want)
                    report_mismatch("result mismatch", got, want);
            end
        end
    end

    always @(posedge aclk) begin : sink_ctrl
        int stall;
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            stall = pick_gap(sink_steady);
            if (stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                sink_hold <= stall - 1;
            end
        end
    end

    // counts cycles with no transfer on either channel and ends the run once STALL_LIMIT is reached
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("json_string_unescape_truncate: mismatch");
            $finish;
        end
    end

    task automatic test_outside_string();
        send_byte(8'hFF);
        send_byte(CH_NUL);
    endtask

    task automatic test_escapes();
        send_byte(CH_QUOTE);
        send_byte(8'hFF);
        send_byte(CH_BSLASH);
        send_byte(CH_T);
        send_byte(CH_BSLASH);
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_SLASH);
        send_byte(CH_QUOTE);
    endtask

    task automatic test_errors();
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte(8'h71);
        send_byte(CH_QUOTE);
        send_byte(8'h1F);
        send_byte(CH_QUOTE);
        send_byte(CH_NUL);
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_NUL);
    endtask

    task automatic test_empty_required();
        set_config(CAPACITY_RESET, 1'b1, 1'b1);
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);
    endtask

    task automatic test_zero_capacity();
        set_config(9'd0, 1'b1, 1'b0);
        send_byte(CH_QUOTE);
    endtask

    // a three-byte sequence cut by the capacity limit is trimmed away
    task automatic test_trimming();
        set_config(9'd3, 1'b1, 1'b0);
        send_byte(CH_QUOTE);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'hAC);
        send_byte(CH_QUOTE);
    endtask

    task automatic test_random_strings(input logic [8:0] cap, input logic capture,
                                       input logic reject_empty, input int n_bytes);
        int start;
        int r;
        int pick;
        int units;
        int brk;
        int limit;
        set_config(cap, capture, reject_empty);
        src_steady = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
        limit = (cap > CAP_LIMIT) ? int'(CAP_LIMIT) : int'(cap);
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            r = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            if (pick < 2 && limit >= 200)
                units = $urandom_range(limit - 4, limit + 6);
            else if (pick < 70)
                units = $urandom_range(0, 8);
            else
                units = $urandom_range(0, (limit < 30) ? limit + 4 : 34);
            if (r < 5) begin
                send_byte(8'($urandom_range(0, 255)));
            end else if (r < 15) begin
                send_byte(CH_QUOTE);
                brk = $urandom_range(0, units);
                send_body(brk);
                case ($urandom_range(0, 3))
                    0: send_byte(8'($urandom_range(1, 31)));
                    1: send_byte(CH_NUL);
                    2: begin
                        send_byte(CH_BSLASH);
                        case ($urandom_range(0, 2))
                            0: send_byte(8'($urandom_range(8'h01, 8'h21)));
                            1: send_byte(8'($urandom_range(8'h30, 8'h5B)));
                            default: send_byte(8'($urandom_range(8'h75, 8'hFF)));
                        endcase
                    end
                    default: begin
                        send_byte(CH_BSLASH);
                        send_byte(CH_NUL);
                    end
                endcase
            end else begin
                send_byte(CH_QUOTE);
                send_body(units);
                send_byte(CH_QUOTE);
            end
            if ($urandom_range(0, 19) == 0)
                src_steady = ~src_steady;
            if ($urandom_range(0, 19) == 0)
                sink_steady = ~sink_steady;
        end
    endtask

    initial begin
        cfg_capacity = CAPACITY_RESET;
        cfg_capture = 1'b1;
        cfg_reject_empty = 1'b0;
        clear_string_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_outside_string();
        test_escapes();
        test_errors();
        test_empty_required();
        test_zero_capacity();
        test_trimming();

        test_random_strings(CAPACITY_RESET, 1'b1, 1'b0, 100);
        test_random_strings(9'd1, 1'b1, 1'b0, 100);
        test_random_strings(9'd2, 1'b1, 1'b1, 100);
        test_random_strings(9'd5, 1'b1, 1'b0, 100);
        test_random_strings(9'd0, 1'b0, 1'b0, 100);
        test_random_strings(9'd0, 1'b1, 1'b0, 30);
        test_random_strings(9'd511, 1'b1, 1'b1, 100);
        test_random_strings(9'd8, 1'b1, 1'b1, 100);
        test_random_strings(9'($urandom_range(3, 40)), 1'b1, 1'b0, 100);
        test_random_strings(9'd257, 1'b0, 1'b1, 100);
        wait_idle();

        if (mismatch_count == 0)
            $display("json_string_unescape_truncate: match");
        else
            $display("json_string_unescape_truncate: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
src/jsu_pkg.sv
src/jsu_cfg.sv
src/jsu_step.sv
src/json_string_unescape_truncate.sv
tb/sv/json_string_unescape_truncate_test.sv
